// ----- hw/rtl/wsps_pkg.sv -----
`default_nettype none
package wsps_pkg;

	// Width of the slot timing counter and of the timing registers.
	localparam int TICK_BITS = 16;
	localparam int BITS_PER_PIXEL = 24;
	localparam int POS_BITS = 5;
	localparam int COLOR_BITS = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic {
		REQ_TICK  = 1'b0,
		REQ_START = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ONE_HIGH   = 3'd0,
		REG_ZERO_HIGH  = 3'd1,
		REG_BIT_PERIOD = 3'd2,
		REG_BRIGHTNESS = 3'd3,
		REG_PIXEL_CNT  = 3'd4
	} reg_idx_t;

	localparam logic [TICK_BITS-1:0]  ONE_HIGH_RST   = 16'd59;
	localparam logic [TICK_BITS-1:0]  ZERO_HIGH_RST  = 16'd28;
	localparam logic [TICK_BITS-1:0]  BIT_PERIOD_RST = 16'd88;
	localparam logic [COLOR_BITS-1:0] BRIGHTNESS_RST = 8'd255;
	localparam logic [COLOR_BITS-1:0] PIXEL_CNT_RST  = 8'd1;

	typedef struct packed {
		logic [TICK_BITS-1:0]  one_high_ticks;
		logic [TICK_BITS-1:0]  zero_high_ticks;
		logic [TICK_BITS-1:0]  bit_period_ticks;
		logic [COLOR_BITS-1:0] brightness_scale;
		logic [COLOR_BITS-1:0] pixel_count;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wsps_req_if.sv -----
`default_nettype none
interface wsps_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, output req_type, output red, output green, output blue,
		input ready);
	modport sink(input valid, input req_type, input red, input green, input blue,
		output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/wsps_res_if.sv -----
`default_nettype none
interface wsps_res_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;

	modport source(output valid, output line_level, output busy_res, input ready);
	modport sink(input valid, input line_level, input busy_res, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/wsps_cfg_regs.sv -----
`default_nettype none
module wsps_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [wsps_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [wsps_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output wsps_pkg::cfg_t                          cfg
);

	wsps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_high_ticks   <= wsps_pkg::ONE_HIGH_RST;
			cfg_q.zero_high_ticks  <= wsps_pkg::ZERO_HIGH_RST;
			cfg_q.bit_period_ticks <= wsps_pkg::BIT_PERIOD_RST;
			cfg_q.brightness_scale <= wsps_pkg::BRIGHTNESS_RST;
			cfg_q.pixel_count      <= wsps_pkg::PIXEL_CNT_RST;
		end else if (cfg_we) begin
			case (wsps_pkg::reg_idx_t'(cfg_idx))
				wsps_pkg::REG_ONE_HIGH: begin
					cfg_q.one_high_ticks <= cfg_data[wsps_pkg::TICK_BITS-1:0];
				end
				wsps_pkg::REG_ZERO_HIGH: begin
					cfg_q.zero_high_ticks <= cfg_data[wsps_pkg::TICK_BITS-1:0];
				end
				wsps_pkg::REG_BIT_PERIOD: begin
					cfg_q.bit_period_ticks <= cfg_data[wsps_pkg::TICK_BITS-1:0];
				end
				wsps_pkg::REG_BRIGHTNESS: begin
					cfg_q.brightness_scale <= cfg_data[wsps_pkg::COLOR_BITS-1:0];
				end
				wsps_pkg::REG_PIXEL_CNT: begin
					cfg_q.pixel_count <= cfg_data[wsps_pkg::COLOR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- hw/rtl/wsps_engine.sv -----
`default_nettype none
module wsps_engine (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire wsps_pkg::cfg_t                  cfg,
	input  wire logic                            step,
	input  wire logic                            req_type,
	input  wire logic [wsps_pkg::COLOR_BITS-1:0] red,
	input  wire logic [wsps_pkg::COLOR_BITS-1:0] green,
	input  wire logic [wsps_pkg::COLOR_BITS-1:0] blue,
	output logic                                 line_level,
	output logic                                 busy_res
);

	localparam int TB = wsps_pkg::TICK_BITS;
	localparam int CB = wsps_pkg::COLOR_BITS;
	localparam int WB = wsps_pkg::BITS_PER_PIXEL;
	localparam int PB = wsps_pkg::POS_BITS;

	logic          sending_q;
	logic [TB-1:0] slot_elapsed_q;
	logic [PB-1:0] bit_position_q;
	logic [CB-1:0] pixels_done_q;
	logic [WB-1:0] grb_word_q;

	logic [2*CB-1:0] prod_r, prod_g, prod_b;
	logic [WB-1:0]   new_word;
	logic            load;
	logic            cur_bit;
	logic [TB-1:0]   cur_high;
	logic [TB-1:0]   new_high;
	logic [TB-1:0]   slot;
	logic            slot_end;
	logic            last_bit;
	logic [CB-1:0]   pixels_next;
	logic            cur_level;

	always_comb begin
		prod_r = {{CB{1'b0}}, red} * {{CB{1'b0}}, cfg.brightness_scale};
		prod_g = {{CB{1'b0}}, green} * {{CB{1'b0}}, cfg.brightness_scale};
		prod_b = {{CB{1'b0}}, blue} * {{CB{1'b0}}, cfg.brightness_scale};
		new_word = {prod_g[2*CB-1:CB], prod_r[2*CB-1:CB], prod_b[2*CB-1:CB]};
		load = (wsps_pkg::req_kind_t'(req_type) == wsps_pkg::REQ_START) && !sending_q
			&& (cfg.pixel_count != '0);

		cur_bit = grb_word_q[PB'(WB - 1) - bit_position_q];
		cur_high = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
		new_high = new_word[WB-1] ? cfg.one_high_ticks : cfg.zero_high_ticks;
		cur_level = sending_q && (slot_elapsed_q < cur_high);

		// A slot lasts the longer of high time and period, and never less than one tick.
		slot = (cur_high > cfg.bit_period_ticks) ? cur_high : cfg.bit_period_ticks;
		if (slot == '0) begin
			slot = TB'(1);
		end
		slot_end = ({1'b0, slot_elapsed_q} + (TB+1)'(1)) >= {1'b0, slot};
		last_bit = bit_position_q == PB'(WB - 1);
		pixels_next = pixels_done_q + CB'(1);

		if (wsps_pkg::req_kind_t'(req_type) == wsps_pkg::REQ_START) begin
			if (load) begin
				line_level = new_high != '0;
				busy_res = 1'b1;
			end else begin
				line_level = cur_level;
				busy_res = sending_q;
			end
		end else begin
			line_level = cur_level;
			busy_res = sending_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			slot_elapsed_q <= '0;
			bit_position_q <= '0;
			pixels_done_q <= '0;
			grb_word_q <= '0;
		end else if (step) begin
			if (wsps_pkg::req_kind_t'(req_type) == wsps_pkg::REQ_START) begin
				if (load) begin
					grb_word_q <= new_word;
					sending_q <= 1'b1;
					slot_elapsed_q <= '0;
					bit_position_q <= '0;
					pixels_done_q <= '0;
				end
			end else if (sending_q) begin
				if (slot_end) begin
					slot_elapsed_q <= '0;
					if (last_bit) begin
						bit_position_q <= '0;
						// The live pixel count decides when the frame ends.
						if (pixels_next >= cfg.pixel_count) begin
							sending_q <= 1'b0;
							pixels_done_q <= '0;
						end else begin
							pixels_done_q <= pixels_next;
						end
					end else begin
						bit_position_q <= bit_position_q + PB'(1);
					end
				end else begin
					slot_elapsed_q <= slot_elapsed_q + TB'(1);
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_position_q < PB'(WB))
		else $error("bit position out of range");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (slot_elapsed_q == '0 && bit_position_q == '0 && pixels_done_q == '0))
		else $error("counters not cleared while idle");
	a_low_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_res |-> !line_level)
		else $error("line high while not busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step && load) |=> sending_q)
		else $error("start did not begin a frame");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/ws2812_pixel_serializer.sv -----
// WS2812 pixel serializer.
// The req channel carries words of req_type, red, green and blue. A tick word
// stands for one tick of line timing; a start word loads a new color, scaled
// by brightness_scale and reordered to GRB, that is then sent MSB first once
// per pixel for pixel_count pixels. A start word while busy is ignored.
// Every req word yields exactly one res word with line_level and busy_res.
// A word accepted into the input register has its result written to the output
// register when it advances. Throughput is one word per cycle while the receiver
// does not stall: the input register, the state update and the output register
// form a two-stage pipe with the logic (three 8x8 scale multiplies and a 17-bit
// slot compare) between them.
// When the receiver stalls, the result stays in the output register and one
// more word is held in the input register; req.ready then drops.
// Reset clears the frame state (idle, line low) and loads the timing
// registers with 59, 28 and 88 ticks, full brightness and one pixel.
// The user writes cfg_we/cfg_idx/cfg_data only while idle; it is unenforced.
`default_nettype none
module ws2812_pixel_serializer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	wsps_req_if.sink                                req,
	wsps_res_if.source                              res,
	input  wire logic                               cfg_we,
	input  wire logic [wsps_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [wsps_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CB = wsps_pkg::COLOR_BITS;

	wsps_pkg::cfg_t cfg;

	logic          valid_s1;
	logic          req_type_s1;
	logic [CB-1:0] red_s1, green_s1, blue_s1;
	logic          advance;
	logic          level, busy;
	logic          res_valid_q;
	logic          line_level_q, busy_q;

	wsps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.cfg     (cfg)
	);

	assign advance = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			red_s1 <= req.red;
			green_s1 <= req.green;
			blue_s1 <= req.blue;
		end
	end

	wsps_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.req_type  (req_type_s1),
		.red       (red_s1),
		.green     (green_s1),
		.blue      (blue_s1),
		.line_level(level),
		.busy_res  (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_level_q <= level;
			busy_q <= busy;
		end
	end

	assign res.valid = res_valid_q;
	assign res.line_level = line_level_q;
	assign res.busy_res = busy_q;

endmodule
`default_nettype wire
